### rtl/sssp_pkg.sv
// Package with shared constants for the shortest path unit.
`default_nettype none
package sssp_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int WeightBits = 16;
  localparam int VtxW = 7;
  localparam int DistW = 22;
  localparam int EdgeAw = $clog2(MaxEdges);
  localparam int EcntW = $clog2(MaxEdges + 1);
  localparam int VidxW = $clog2(MaxVertices);
  localparam int EdgeW = 2 * VtxW + WeightBits;
  localparam int VtabW = DistW + VtxW;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic OpAdd = 1'b0;
  localparam logic OpRun = 1'b1;
endpackage
`default_nettype wire

### rtl/sssp_ram.sv
// Generic single-port-write RAM with one registered read port.
`default_nettype none
module sssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/single_source_shortest_path_unit.sv
// Top level of the single-source shortest path unit.
// An edge beat is stored while the unit stays in S_IDLE, so in_tready stays high for the next beat.
// A run beat starts a search over the reached vertices and the stored edges, then n result
// beats are sent, the last held until out_tready; in_tready stays low until it is taken.
// rst_n clears the edge count, overflow flag, vertex count (to 64) and control state.
`default_nettype none
module single_source_shortest_path_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op, edge_from, edge_to, edge_weight, source_vertex, zero fill
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // vertex, distance, reachable, predecessor, edges_dropped, zero fill
  output logic [39:0]      out_tdata,
  output logic             out_tlast
);
  import sssp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PICK, S_PCMP, S_PDONE, S_EREQ, S_ELOOK, S_EDGE, S_OREQ, S_OUT, S_ODRAIN
  } state_t;

  state_t state_r;
  logic [VtxW-1:0]   nv_r, n_r;
  logic [EcntW-1:0]  ecnt_r;
  logic [EcntW-1:0]  eidx_r;
  logic              ovf_r, drop_r;
  logic [VidxW:0]    k_r;
  logic [VtxW-1:0]   best_r;
  logic [DistW-1:0]  bestd_r;
  logic [MaxVertices-1:0] fin_r, rch_r;

  logic              op;
  logic [VtxW-1:0]   efrom, eto, srcin;
  logic [WeightBits-1:0] ew;
  logic              acc;
  logic              ram_we;
  logic [EdgeW-1:0]  ram_rd;
  logic [VtxW-1:0]   rt, rh;
  logic [WeightBits-1:0] rw;
  logic [VidxW-1:0]  ki, hi, bi, si;
  logic              kval, hval, better, lt, src_ok;
  logic [DistW:0]    sum;
  logic [DistW-1:0]  cand, cmp_a, cmp_b;
  logic [VtxW-1:0]   nclip;
  logic [MaxVertices-1:0] src_hot;
  logic              vt_we;
  logic [VidxW-1:0]  vt_waddr, vt_raddr;
  logic [VtabW-1:0]  vt_wdata, vt_rd;
  logic [DistW-1:0]  vt_dist;
  logic [VtxW-1:0]   vt_pred;

  assign op    = in_tdata[0];
  assign efrom = in_tdata[7:1];
  assign eto   = in_tdata[14:8];
  assign ew    = in_tdata[30:15];
  assign srcin = in_tdata[37:31];

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  assign ram_we = acc && (op == OpAdd) && (ecnt_r < EcntW'(MaxEdges));
  sssp_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
    .clk(clk), .we(ram_we), .waddr(ecnt_r[EdgeAw-1:0]),
    .wdata({ew, eto, efrom}), .raddr(eidx_r[EdgeAw-1:0]), .rdata(ram_rd)
  );

  assign rt = ram_rd[VtxW-1:0];
  assign rh = ram_rd[2*VtxW-1:VtxW];
  assign rw = ram_rd[EdgeW-1:2*VtxW];

  assign nclip = (nv_r == '0) ? 7'd1 :
                 (nv_r > VtxW'(MaxVertices)) ? VtxW'(MaxVertices) : nv_r;

  // Shared compare unit: k_r walks vertices, edge head index derived from rh.
  assign ki = k_r[VidxW-1:0];
  assign hi = VidxW'(rh - 7'd1);
  assign bi = VidxW'(best_r - 7'd1);
  assign si = VidxW'(srcin - 7'd1);
  assign src_ok = (srcin != '0) && (srcin <= nclip);
  assign src_hot = src_ok ? (MaxVertices'(1) << si) : '0;

  // Distance and predecessor of each vertex; only entries of reached vertices are used.
  assign vt_raddr = (state_r == S_ELOOK || state_r == S_EDGE) ? hi : ki;
  assign vt_we = (acc && (op == OpRun)) || ((state_r == S_EDGE) && better);
  assign vt_waddr = (state_r == S_EDGE) ? hi : si;
  assign vt_wdata = (state_r == S_EDGE) ? {best_r, cand} : '0;
  sssp_ram #(.Width(VtabW), .Depth(MaxVertices)) u_vtab (
    .clk(clk), .we(vt_we), .waddr(vt_waddr),
    .wdata(vt_wdata), .raddr(vt_raddr), .rdata(vt_rd)
  );
  assign vt_dist = vt_rd[DistW-1:0];
  assign vt_pred = vt_rd[VtabW-1:DistW];

  assign sum = {1'b0, bestd_r} + (DistW+1)'(rw);
  assign cand = sum[DistW] ? DistMax : sum[DistW-1:0];
  assign cmp_a = (state_r == S_EDGE) ? cand : vt_dist;
  assign cmp_b = (state_r == S_EDGE) ? vt_dist : bestd_r;
  assign lt = cmp_a < cmp_b;
  assign kval = rch_r[ki] && !fin_r[ki];
  assign hval = (rt == best_r) && (rh != '0) && (rh <= n_r);
  assign better = hval && (!rch_r[hi] || lt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nv_r <= VtxW'(MaxVertices);
      ecnt_r <= '0;
      ovf_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) nv_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (op == OpAdd) begin
              if (ecnt_r < EcntW'(MaxEdges)) ecnt_r <= ecnt_r + 1'b1;
              else ovf_r <= 1'b1;
            end else begin
              n_r <= nclip;
              drop_r <= ovf_r;
              fin_r <= '0;
              rch_r <= src_hot;
              k_r <= '0;
              best_r <= '0;
              state_r <= S_PICK;
            end
          end
        end
        S_PICK: state_r <= S_PCMP;
        S_PCMP: begin
          if (kval && (best_r == '0 || lt)) begin
            best_r <= VtxW'(k_r) + 7'd1;
            bestd_r <= vt_dist;
          end
          if (VtxW'(k_r) + 7'd1 >= n_r) begin
            state_r <= S_PDONE;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_PICK;
          end
        end
        S_PDONE: begin
          if (best_r == '0) begin
            k_r <= '0;
            state_r <= S_OREQ;
          end else begin
            fin_r[bi] <= 1'b1;
            eidx_r <= '0;
            state_r <= (ecnt_r == '0) ? S_PICK : S_EREQ;
            k_r <= '0;
            if (ecnt_r == '0) best_r <= '0;
          end
        end
        S_EREQ: state_r <= S_ELOOK;
        S_ELOOK: state_r <= S_EDGE;
        S_EDGE: begin
          if (better) begin
            rch_r[hi] <= 1'b1;
          end
          if (eidx_r + 1'b1 >= ecnt_r) begin
            best_r <= '0;
            k_r <= '0;
            state_r <= S_PICK;
          end else begin
            eidx_r <= eidx_r + 1'b1;
            state_r <= S_EREQ;
          end
        end
        S_OREQ: begin
          if (out_tready) out_tvalid <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata <= {2'b00, drop_r,
                          rch_r[ki] ? vt_pred : 7'd0,
                          rch_r[ki],
                          rch_r[ki] ? vt_dist : 22'd0,
                          VtxW'(k_r) + 7'd1};
            out_tlast <= (VtxW'(k_r) + 7'd1 == n_r);
            if (VtxW'(k_r) + 7'd1 >= n_r) begin
              state_r <= S_ODRAIN;
            end else begin
              k_r <= k_r + 1'b1;
              state_r <= S_OREQ;
            end
          end
        end
        S_ODRAIN: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            ecnt_r <= '0;
            ovf_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
